FILE: hdl/g2l_pkg.sv
// ----------------------------------------------------------------------------
// g2l_pkg
// Shared types, year table and calendar helpers for the Gregorian to lunar
// date converter.
// ----------------------------------------------------------------------------
package g2l_pkg;

  localparam int FIRST_YEAR = 1901;
  localparam int YEAR_COUNT = 199;
  localparam int ROM_DEPTH  = 199;

  typedef struct packed {
    logic [11:0] greg_year;
    logic [3:0]  greg_month;
    logic [4:0]  greg_day;
  } req_t;

  typedef struct packed {
    logic        valid_res;
    logic [11:0] lunar_year;
    logic [3:0]  lunar_month;
    logic [4:0]  lunar_day;
    logic        leap_month_flag;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NEWYR,
    ST_PREV,
    ST_FWD,
    ST_BACK,
    ST_DONE
  } state_t;

  // sequencer -> datapath
  typedef struct packed {
    logic idle;
    logic take;
    logic check;
    logic newyr;
    logic prev;
    logic fwd;
    logic back;
    logic rom_en;
    logic rom_prev;
    logic push;
  } ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic date_ok;
    logic after_ny;
    logic has_prev;
    logic walk_more;
  } stat_t;

  // leap month [23:20], month lengths [19:7], new-year month [6:5], day [4:0]
  localparam logic [23:0] YEAR_ROM [0:ROM_DEPTH-1] = '{
    24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544, 24'h46AAB9, 24'h056A4D,
    24'h09AD42, 24'h24AEB6, 24'h04AE4A, 24'h6A4DBE, 24'h0A4D52, 24'h0D2546, 24'h5D52BA,
    24'h0B544E, 24'h0D6A43, 24'h296D37, 24'h095B4B, 24'h749BC1, 24'h049754, 24'h0A4B48,
    24'h5B25BC, 24'h06A550, 24'h06D445, 24'h4ADAB8, 24'h02B64D, 24'h095742, 24'h2497B7,
    24'h04974A, 24'h664B3E, 24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644,
    24'h393738, 24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48, 24'h6DA53B, 24'h0B554F,
    24'h056A45, 24'h4AADB9, 24'h025D4D, 24'h092D42, 24'h2C95B6, 24'h0A954A, 24'h7B4ABD,
    24'h06CA51, 24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43, 24'h352BB8, 24'h052B4C,
    24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h6AD53C, 24'h0AB54F, 24'h04B645, 24'h4A5739,
    24'h0A574D, 24'h052642, 24'h3E9335, 24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46,
    24'h54AEBB, 24'h04AD4F, 24'h0A4D43, 24'h4D26B7, 24'h0D254B, 24'h8D52BF, 24'h0B5452,
    24'h0B6A47, 24'h696D3C, 24'h095B50, 24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2,
    24'h06A554, 24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h095746, 24'h5497BB, 24'h04974F,
    24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF, 24'h05AC53, 24'h0AB647, 24'h5936BC,
    24'h092E50, 24'h0C9645, 24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49,
    24'h7AADBD, 24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E, 24'h0B4A43, 24'h4B5537,
    24'h0AD54A, 24'h955ABF, 24'h04BA53, 24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345,
    24'h474AB9, 24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D, 24'h0A4E51,
    24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43, 24'h36B537, 24'h096D4B, 24'hB4AEBF,
    24'h04AD53, 24'h0A4D48, 24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
    24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51, 24'h0AA546, 24'h5B52BA,
    24'h06D24E, 24'h0ADA42, 24'h355B37, 24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48,
    24'h66A53C, 24'h0EA54F, 24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42, 24'h3C9735,
    24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545, 24'h55AABA, 24'h056A4E, 24'h0A6D43,
    24'h452EB7, 24'h052D4B, 24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F,
    24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6, 24'h069349, 24'h7729BD,
    24'h06AA51, 24'h0AD546, 24'h54DABA, 24'h04B64E, 24'h0A5743, 24'h452738, 24'h0D264A,
    24'h8E933E, 24'h0D5252, 24'h0DAA47, 24'h66B53B, 24'h056D4F, 24'h04AE45, 24'h4A4EB9,
    24'h0A4D4C, 24'h0D1541, 24'h2D92B5
  };

  function automatic logic [23:0] year_word(input logic [7:0] idx);
    logic [23:0] w;
    w = '0;
    if (idx < 8'(ROM_DEPTH)) begin
      w = YEAR_ROM[idx];
    end
    return w;
  endfunction

  // month slot 1..13 -> 29 or 30 days, anything else 29
  function automatic logic [4:0] slot_len(input logic [23:0] word, input logic [3:0] slot);
    logic [12:0] bits;
    logic [3:0]  pos;
    logic [4:0]  len;
    bits = word[19:7];
    pos  = 4'd13 - slot;
    len  = 5'd29;
    if (slot >= 4'd1 && slot <= 4'd13) begin
      len = bits[pos] ? 5'd30 : 5'd29;
    end
    return len;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] v;
    case (month)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] v;
    case (month)
      4'd2:                        v = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:     v = 5'd30;
      default:                     v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/g2l_rom.sv
// ----------------------------------------------------------------------------
// g2l_rom
// Year table with a registered read port.
// ----------------------------------------------------------------------------
module g2l_rom #(
  parameter int YEAR_COUNT = g2l_pkg::YEAR_COUNT,
  parameter int IW = (YEAR_COUNT > 1) ? $clog2(YEAR_COUNT) : 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [IW-1:0] addr,
  output logic [23:0]   data
);

  always_ff @(posedge clk) begin
    if (en) begin
      data <= g2l_pkg::year_word(8'(addr));
    end
  end

endmodule

FILE: hdl/g2l_seq.sv
// ----------------------------------------------------------------------------
// g2l_seq
// Sequencer: validate, look up the new year, then walk months one per cycle.
// ----------------------------------------------------------------------------
module g2l_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             out_free,
  input  g2l_pkg::stat_t   stat,
  output g2l_pkg::ctrl_t   ctrl
);

  g2l_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= g2l_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      g2l_pkg::ST_IDLE: begin
        if (req_valid) state_next = g2l_pkg::ST_CHECK;
      end
      g2l_pkg::ST_CHECK: begin
        state_next = stat.date_ok ? g2l_pkg::ST_NEWYR : g2l_pkg::ST_DONE;
      end
      g2l_pkg::ST_NEWYR: begin
        if (stat.after_ny)      state_next = g2l_pkg::ST_FWD;
        else if (stat.has_prev) state_next = g2l_pkg::ST_PREV;
        else                    state_next = g2l_pkg::ST_DONE;
      end
      g2l_pkg::ST_PREV: begin
        state_next = g2l_pkg::ST_BACK;
      end
      g2l_pkg::ST_FWD, g2l_pkg::ST_BACK: begin
        if (!stat.walk_more) state_next = g2l_pkg::ST_DONE;
      end
      g2l_pkg::ST_DONE: begin
        if (out_free) state_next = g2l_pkg::ST_IDLE;
      end
      default: state_next = g2l_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      g2l_pkg::ST_IDLE: begin
        ctrl.idle = 1'b1;
        ctrl.take = req_valid;
      end
      g2l_pkg::ST_CHECK: begin
        ctrl.check  = 1'b1;
        ctrl.rom_en = 1'b1;
      end
      g2l_pkg::ST_NEWYR: begin
        ctrl.newyr = 1'b1;
        // previous year's word; the top holds this year's word on a forward walk
        ctrl.rom_en   = 1'b1;
        ctrl.rom_prev = 1'b1;
      end
      g2l_pkg::ST_PREV: ctrl.prev = 1'b1;
      g2l_pkg::ST_FWD:  ctrl.fwd  = 1'b1;
      g2l_pkg::ST_BACK: ctrl.back = 1'b1;
      g2l_pkg::ST_DONE: ctrl.push = out_free;
      default: ctrl = '0;
    endcase
  end

endmodule

FILE: hdl/g2l_dp.sv
// ----------------------------------------------------------------------------
// g2l_dp
// Datapath: date check, day of year and the shared subtract/compare unit
// that does the new-year compare, the count-back set-up and each month step.
// ----------------------------------------------------------------------------
module g2l_dp #(
  parameter int YEAR_COUNT = g2l_pkg::YEAR_COUNT,
  parameter int IW = (YEAR_COUNT > 1) ? $clog2(YEAR_COUNT) : 1
) (
  input  logic           clk,
  input  g2l_pkg::ctrl_t ctrl,
  input  g2l_pkg::req_t  req,
  input  logic [23:0]    word,
  output logic [IW-1:0]  rom_addr,
  output g2l_pkg::stat_t stat,
  output g2l_pkg::res_t  result
);

  localparam logic [11:0] FIRST = 12'(g2l_pkg::FIRST_YEAR);
  localparam logic [11:0] LAST  = 12'(g2l_pkg::FIRST_YEAR + YEAR_COUNT - 1);

  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [8:0]  doy1;    // day of year, one-based
  logic [8:0]  rem;
  logic [3:0]  slot;
  logic [3:0]  lm;
  logic [3:0]  lp;
  logic [3:0]  cnt;
  logic        tog;

  logic [11:0] yidx, yprev;
  logic        leap;
  logic [8:0]  doy1_calc;
  logic [5:0]  nyp1;    // new-year offset, one-based
  logic [4:0]  len;
  logic [8:0]  op_a, op_b;
  logic [9:0]  diff;
  logic        neg;
  logic [3:0]  lm_fwd, lm_dec, lm_back;
  logic        tog_fwd, tog_back, lf;

  assign yidx  = year - FIRST;
  assign yprev = yidx - 12'd1;
  assign rom_addr = ctrl.rom_prev ? yprev[IW-1:0] : yidx[IW-1:0];

  // every table year lies in 1901..2099, where the four-year rule is exact
  assign leap = (year[1:0] == 2'b00);
  assign doy1_calc = g2l_pkg::month_start(month) + 9'(day)
                   + 9'((leap && month > 4'd2) ? 1 : 0);

  assign nyp1 = 6'(word[4:0]) + ((word[6:5] != 2'd1) ? 6'd31 : 6'd0);
  assign len  = g2l_pkg::slot_len(word, slot);

  // shared subtractor
  always_comb begin
    op_a = rem;
    op_b = 9'(len);
    if (ctrl.newyr) begin
      op_a = doy1;
      op_b = 9'(nyp1);
    end else if (ctrl.prev) begin
      op_b = doy1;
    end
  end
  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign neg  = diff[9];

  assign stat.date_ok = (year >= FIRST) && (year <= LAST)
                      && (month >= 4'd1) && (month <= 4'd12) && (day != 5'd0)
                      && (day <= g2l_pkg::month_len(month, leap));
  assign stat.after_ny  = !neg;
  assign stat.has_prev  = (yidx != 12'd0);
  assign stat.walk_more = ctrl.back ? (!neg && diff != 10'd0) : !neg;

  // forward walk: the leap month repeats once before the count moves on
  assign tog_fwd = (lm == lp) ? !tog : tog;
  assign lm_fwd  = ((lm == lp) && !tog) ? lm : lm + 4'd1;
  // backward walk
  assign lm_dec   = tog ? lm : lm - 4'd1;
  assign tog_back = (lm_dec == lp) ? !tog : tog;
  assign lm_back  = lm_dec;

  assign lf = (lm == lp) && (lm != cnt);

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      year  <= req.greg_year;
      month <= req.greg_month;
      day   <= req.greg_day;
    end
    if (ctrl.check) begin
      doy1 <= doy1_calc;
      if (!stat.date_ok) result <= '0;
    end
    if (ctrl.newyr) begin
      if (!neg) begin
        rem  <= diff[8:0];
        slot <= 4'd1;
        lm   <= 4'd1;
        tog  <= 1'b0;
        cnt  <= 4'd1;
        lp   <= word[23:20];
      end else if (stat.has_prev) begin
        rem <= 9'(nyp1);
      end else begin
        result <= '0;
      end
    end
    if (ctrl.prev) begin
      rem  <= diff[8:0];
      lp   <= word[23:20];
      slot <= (word[23:20] == 4'd0) ? 4'd12 : 4'd13;
      lm   <= 4'd12;
      tog  <= 1'b0;
      cnt  <= 4'd1;
    end
    if (ctrl.fwd) begin
      if (stat.walk_more) begin
        rem  <= diff[8:0];
        slot <= slot + 4'd1;
        lm   <= lm_fwd;
        tog  <= tog_fwd;
        cnt  <= cnt + 4'd1;
      end else begin
        result.valid_res       <= 1'b1;
        result.lunar_year      <= year;
        result.lunar_month     <= lm;
        result.lunar_day       <= rem[4:0] + 5'd1;
        result.leap_month_flag <= lf;
      end
    end
    if (ctrl.back) begin
      if (stat.walk_more) begin
        rem  <= diff[8:0];
        slot <= slot - 4'd1;
        lm   <= lm_back;
        tog  <= tog_back;
        cnt  <= cnt + 4'd1;
      end else begin
        result.valid_res       <= 1'b1;
        result.lunar_year      <= year - 12'd1;
        result.lunar_month     <= lm;
        result.lunar_day       <= len - rem[4:0] + 5'd1;
        result.leap_month_flag <= lf;
      end
    end
  end

endmodule

FILE: hdl/gregorian_to_lunar_date.sv
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date
// Converts a Gregorian date to the Chinese lunar date from a fixed year table.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_valid/req_stall/req carries one Gregorian date.
//   Result channel res_valid/res_stall/res carries one lunar date per
//   request; valid_res is 0 for an invalid date, a year outside the table,
//   or a date before the first table year's new year.
//   A request is taken when req_valid is high and req_stall low; req_stall
//   then stays high until the result is loaded into the output register.
//   A conversion steps through the date check, the new-year compare, a
//   set-up from the prior year's word when counting back, one step per month
//   through the shared subtractor, and the output load; a forward walk
//   passes at most 11 whole months. A malformed date or a year outside
//   the table goes from the check straight to the output load.
//   Requests are handled one at a time, so the month walk sets the rate.
//   The result sits in an output register, so a new request is taken while
//   the last result is still stalled; the sequencer then waits to deliver.
//   Synchronous reset returns the sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
module gregorian_to_lunar_date #(
  parameter int YEAR_COUNT = g2l_pkg::YEAR_COUNT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  g2l_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output g2l_pkg::res_t res
);

  localparam int IW = (YEAR_COUNT > 1) ? $clog2(YEAR_COUNT) : 1;

  g2l_pkg::ctrl_t ctrl;
  g2l_pkg::stat_t stat;
  g2l_pkg::res_t  result;
  logic [IW-1:0]  rom_addr;
  logic [23:0]    word;
  logic           out_free;
  logic           rom_en;

  assign out_free  = !res_valid || !res_stall;
  assign req_stall = !ctrl.idle;
  // keep this year's word when the walk goes forward
  assign rom_en    = ctrl.rom_en && !(ctrl.newyr && stat.after_ny);

  g2l_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  g2l_rom #(.YEAR_COUNT(YEAR_COUNT), .IW(IW)) u_rom (
    .clk (clk),
    .en  (rom_en),
    .addr(rom_addr),
    .data(word)
  );

  g2l_dp #(.YEAR_COUNT(YEAR_COUNT), .IW(IW)) u_dp (
    .clk     (clk),
    .ctrl    (ctrl),
    .req     (req),
    .word    (word),
    .rom_addr(rom_addr),
    .stat    (stat),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.push) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      res <= result;
    end
  end

endmodule

FILE: hdl/g2l_check.sv
// ----------------------------------------------------------------------------
// g2l_check
// Port-level checks for the lunar date converter.
// ----------------------------------------------------------------------------
module g2l_check (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input g2l_pkg::req_t req,
  input logic          res_valid,
  input logic          res_stall,
  input g2l_pkg::res_t res
);

  // one request at a time: busy right after a request is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while a conversion was in flight");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result present after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.valid_res) |->
      (res.lunar_year == 12'd0 && res.lunar_month == 4'd0 &&
       res.lunar_day == 5'd0 && !res.leap_month_flag))
    else $error("rejected date carries nonzero fields");

  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.valid_res) |->
      (res.lunar_month >= 4'd1 && res.lunar_month <= 4'd12 &&
       res.lunar_day >= 5'd1 && res.lunar_day <= 5'd30))
    else $error("lunar month or day out of range");

endmodule

bind gregorian_to_lunar_date g2l_check u_check (.*);

FILE: tb/sv/gregorian_to_lunar_date_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date_tb
// Self-checking bench for the Gregorian to lunar date converter. Drives
// directed calendar corners, then about 1550 mostly well-formed random dates
// through several sender/receiver idling phases, including a long result
// hold-off. Every result is checked field by field against an in-bench
// calendar predictor built on the package year table.
// ----------------------------------------------------------------------------
module gregorian_to_lunar_date_tb;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 24;

  // Expected lunar dates in request order, plus run statistics.
  class lunar_board;
    g2l_pkg::res_t lunar_q[$];
    int   errors;
    int   n_req;
    int   n_ok;
    int   n_back;
    int   n_leap;

    function new();
      errors = 0;
      n_req  = 0;
      n_ok   = 0;
      n_back = 0;
      n_leap = 0;
    endfunction

    static function bit is_leap(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int month_days(int y, int m);
      int dim [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m == 2 && is_leap(y)) return 29;
      return dim[m-1];
    endfunction

    // bit 19 holds slot 1, bit 7 slot 13; anything outside counts as short
    static function int slot_days(logic [23:0] w, int s);
      if (s < 1 || s > 13) return 29;
      return w[20 - s] ? 30 : 29;
    endfunction

    function g2l_pkg::res_t convert(g2l_pkg::req_t r);
      int cum [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      int y, m, d, ny, doy, rem, s, len, lp, cnt, lm, ld, ly;
      bit tog, ok;
      logic [23:0] w;
      g2l_pkg::res_t o;
      o   = '0;
      y   = int'(r.greg_year);
      m   = int'(r.greg_month);
      d   = int'(r.greg_day);
      ok  = 1'b0;
      tog = 1'b0;
      lp  = 0;
      lm  = 0;
      ld  = 0;
      ly  = 0;
      cnt = 1;
      if (y < g2l_pkg::FIRST_YEAR ||
          y > g2l_pkg::FIRST_YEAR + g2l_pkg::YEAR_COUNT - 1 ||
          m < 1 || m > 12 || d < 1)
        return o;
      if (d > month_days(y, m)) return o;
      w  = g2l_pkg::YEAR_ROM[y - g2l_pkg::FIRST_YEAR];
      ny = int'(w[4:0]) - 1;
      if (w[6:5] != 2'd1) ny += 31;
      doy = cum[m-1] + d - 1;
      if (is_leap(y) && m > 2) doy++;
      if (doy >= ny) begin
        rem = doy - ny;
        s   = 1;
        len = slot_days(w, s);
        lp  = int'(w[23:20]);
        lm  = 1;
        while (rem >= len) begin
          rem -= len;
          s++;
          // the leap slot repeats its month number once
          if (lm == lp) begin
            tog = !tog;
            if (!tog) lm++;
          end else begin
            lm++;
          end
          len = slot_days(w, s);
          cnt++;
        end
        ld = rem + 1;
        ly = y;
        ok = 1'b1;
      end else if (y - 1 >= g2l_pkg::FIRST_YEAR) begin
        // before new year: count back from the last slot of last year
        w   = g2l_pkg::YEAR_ROM[y - 1 - g2l_pkg::FIRST_YEAR];
        rem = ny - doy;
        lp  = int'(w[23:20]);
        s   = (lp == 0) ? 12 : 13;
        len = slot_days(w, s);
        lm  = 12;
        while (rem > len) begin
          rem -= len;
          s--;
          if (!tog) lm--;
          if (lm == lp) tog = !tog;
          len = slot_days(w, s);
          cnt++;
        end
        ld = len - rem + 1;
        ly = y - 1;
        ok = 1'b1;
        n_back++;
      end
      if (ok) begin
        o.valid_res       = 1'b1;
        o.lunar_year      = ly[11:0];
        o.lunar_month     = lm[3:0];
        o.lunar_day       = ld[4:0];
        o.leap_month_flag = (lm == lp) && (lm != cnt);
      end
      return o;
    endfunction

    function void note_request(g2l_pkg::req_t r);
      g2l_pkg::res_t e;
      e = convert(r);
      lunar_q.push_back(e);
      n_req++;
      if (e.valid_res) n_ok++;
      if (e.leap_month_flag) n_leap++;
    endfunction

    function void cmp_field(string name, int e, int a);
      if (e != a) begin
        $error("%s: expected %0d, actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(g2l_pkg::res_t a);
      g2l_pkg::res_t e;
      if (lunar_q.size() == 0) begin
        $error("result with no request outstanding: %h", a);
        errors++;
        return;
      end
      e = lunar_q.pop_front();
      cmp_field("valid_res", e.valid_res, a.valid_res);
      cmp_field("lunar_year", e.lunar_year, a.lunar_year);
      cmp_field("lunar_month", e.lunar_month, a.lunar_month);
      cmp_field("lunar_day", e.lunar_day, a.lunar_day);
      cmp_field("leap_month_flag", e.leap_month_flag, a.leap_month_flag);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  g2l_pkg::req_t req_data;
  logic res_valid;
  logic res_stall;
  g2l_pkg::res_t res_data;

  lunar_board sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_ticket;
  int hold_seen;
  int hold_cnt;
  int idle_cycles;

  gregorian_to_lunar_date u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check, then decide next cycle's stall
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_cnt  = 0;
      hold_seen = hold_ticket;
    end else begin
      if (res_valid && !res_stall) sb.check_result(res_data);
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic g2l_pkg::req_t mk_date(int y, int m, int d);
    g2l_pkg::req_t r;
    r.greg_year  = y[11:0];
    r.greg_month = m[3:0];
    r.greg_day   = d[4:0];
    return r;
  endfunction

  // mostly real dates, biased to new-year season and table ends; some noise
  function automatic g2l_pkg::req_t pick_date();
    int kind, y, m, d;
    kind = $urandom_range(99);
    if (kind < 82) begin
      if (kind < 10) begin
        case ($urandom_range(3))
          0:       y = 1901;
          1:       y = 1902;
          2:       y = 2098;
          default: y = 2099;
        endcase
      end else begin
        y = $urandom_range(2099, 1901);
      end
      m = (kind < 35) ? $urandom_range(2, 1) : $urandom_range(12, 1);
      d = $urandom_range(lunar_board::month_days(y, m), 1);
    end else if (kind < 91) begin
      y = $urandom_range(2099, 1901);
      m = $urandom_range(15, 0);
      d = $urandom_range(31, 0);
    end else begin
      y = $urandom_range(4095, 0);
      m = $urandom_range(15, 0);
      d = $urandom_range(31, 0);
    end
    return mk_date(y, m, d);
  endfunction

  task automatic send_item(input g2l_pkg::req_t r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic run_phase(input int n, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) send_item(pick_date());
  endtask

  initial begin
    sb             = new();
    clk            = 1'b0;
    rst            = 1'b1;
    req_valid      = 1'b0;
    req_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ticket    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_item(mk_date(0, 0, 0));
    send_item(mk_date(4095, 15, 31));
    send_item(mk_date(1900, 12, 31));
    send_item(mk_date(2100, 1, 1));
    send_item(mk_date(1901, 1, 1));     // before the first lunar new year
    send_item(mk_date(1901, 2, 18));
    send_item(mk_date(1901, 2, 19));    // first convertible date
    send_item(mk_date(1902, 1, 1));     // walks back into the first year
    send_item(mk_date(2099, 12, 31));
    send_item(mk_date(2099, 1, 1));
    send_item(mk_date(2000, 2, 29));
    send_item(mk_date(2001, 2, 29));
    send_item(mk_date(2004, 2, 29));
    send_item(mk_date(2023, 4, 31));
    send_item(mk_date(2023, 13, 1));
    send_item(mk_date(2023, 0, 10));
    send_item(mk_date(2023, 6, 0));
    send_item(mk_date(2000, 1, 1));
    send_item(mk_date(2023, 1, 21));    // new-year eve
    send_item(mk_date(2023, 1, 22));
    send_item(mk_date(2023, 4, 1));     // intercalary second month
    send_item(mk_date(2020, 6, 1));     // intercalary fourth month
    send_item(mk_date(2020, 6, 21));
    send_item(mk_date(1903, 7, 15));
    send_item(mk_date(2033, 12, 25));

    run_phase(350, 0, 0);
    run_phase(300, 71, 0);
    run_phase(300, 0, 71);
    run_phase(300, 38, 38);
    // long result hold-off while requests keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ticket++;
    run_phase(300, 0, 0);

    req_valid <= 1'b0;
    while (sb.lunar_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d converted (%0d counted back into the prior year,",
             sb.n_req, sb.n_ok, sb.n_back);
    $display("  %0d in leap months), %0d rejected, over five idling phases incl. a hold-off",
             sb.n_leap, sb.n_req - sb.n_ok);
    if (sb.errors == 0 && sb.lunar_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
